[sv/fal_pkg.sv]
// ============================================================================
// fal_pkg: shared types and constants of the fixed-capacity list
//
// Capacity, derived widths, request and status codes, sequencer states,
// the item structs and the memory control struct.
// ============================================================================
package fal_pkg;

	localparam int CAPACITY = 128;
	localparam int DATA_W   = 32;
	localparam int IDX_W    = 7;
	localparam int LEN_W    = 8;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > IDX_W) ? CNT_W : IDX_W;

	typedef logic [ADDR_W-1:0] addr_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [CMP_W-1:0]  cmp_t;
	typedef logic [LEN_W-1:0]  len_t;

	typedef enum logic [1:0] {
		REQ_APPEND = 2'd0,
		REQ_READ   = 2'd1,
		REQ_WRITE  = 2'd2,
		REQ_REMOVE = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_RESP
	} seq_state_t;

	typedef struct packed {
		req_type_t                req_type;
		logic [IDX_W-1:0]         index;
		logic signed [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		len_t                     list_length;
		status_t                  status;
	} rsp_t;

	typedef struct packed {
		logic              we;
		addr_t             waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		addr_t             raddr;
	} ram_ctl_t;

endpackage

[sv/fixed_array_list.sv]
// ============================================================================
// fixed_array_list: fixed-capacity list of signed 32-bit words
//
// Appends, reads, overwrites and removes entries held in one memory; a
// remove shifts the later entries down one place, one entry per cycle.
// ============================================================================
//
//   channel   valid       stall       item
//   -------   ---------   ---------   -------------------------------
//   request   req_valid   req_stall   req (req_type, index, value)
//   result    rsp_valid   rsp_stall   rsp (read_value, list_length, status)
//
// Append, read and write go from idle to the response state, which loads the result
// once the output is free. A remove at index i first passes the shift state, where
// the single memory port pair moves later entries down one place, one entry a cycle.
// One request is in progress at a time; req_stall is high until its result is loaded,
// and a stalled result holds the next one back, and with it the input.
// Reset clears the length; the memory contents are not cleared.
module fixed_array_list (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  fal_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fal_pkg::rsp_t  rsp
);

	fal_pkg::ram_ctl_t          ram;
	logic [fal_pkg::DATA_W-1:0] rdata;
	logic                       res_load;
	fal_pkg::rsp_t              res;
	logic                       out_free;
	logic                       rsp_valid_q;
	fal_pkg::rsp_t              rsp_q;

	assign out_free = !rsp_valid_q || !rsp_stall;

	fal_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req      (req),
		.busy     (req_stall),
		.out_free (out_free),
		.rdata    (rdata),
		.ram      (ram),
		.res_load (res_load),
		.res      (res)
	);

	fal_ram #(
		.WIDTH(fal_pkg::DATA_W),
		.DEPTH(fal_pkg::CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram.we),
		.waddr(ram.waddr),
		.wdata(ram.wdata),
		.re   (ram.re),
		.raddr(ram.raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/fal_ram.sv]
// ============================================================================
// fal_ram: generic simple dual-port memory
//
// One write port and one read port; the read data is registered and holds
// its value while no read is enabled.
// ============================================================================
module fal_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/fal_seq.sv]
// ============================================================================
// fal_seq: request sequencer of the fixed-capacity list
//
// Checks each request against the length, drives the memory port, runs the
// one-entry-per-cycle shift of a remove and builds the result item.
// ============================================================================
module fal_seq (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  fal_pkg::req_t             req,
	output logic                      busy,
	input  logic                      out_free,
	input  logic [fal_pkg::DATA_W-1:0] rdata,
	output fal_pkg::ram_ctl_t         ram,
	output logic                      res_load,
	output fal_pkg::rsp_t             res
);

	fal_pkg::seq_state_t state_q;
	fal_pkg::seq_state_t state_d;
	fal_pkg::cnt_t       count_q;
	fal_pkg::cnt_t       rptr_q;
	fal_pkg::addr_t      waddr_s1;
	logic                pend_s1;
	fal_pkg::status_t    status_q;
	fal_pkg::status_t    status_c;
	logic                is_read_q;
	fal_pkg::cmp_t       idx_c;
	fal_pkg::cmp_t       cnt_c;
	logic                full_c;
	logic                range_c;
	logic                issue_c;
	logic                accept_c;

	assign idx_c    = fal_pkg::cmp_t'(req.index);
	assign cnt_c    = fal_pkg::cmp_t'(count_q);
	assign full_c   = (count_q == fal_pkg::cnt_t'(fal_pkg::CAPACITY));
	assign range_c  = (idx_c >= cnt_c);
	assign issue_c  = (rptr_q < count_q);
	assign accept_c = (state_q == fal_pkg::S_IDLE) && req_valid;

	always_comb begin
		if (req.req_type == fal_pkg::REQ_APPEND) begin
			status_c = full_c ? fal_pkg::ST_FULL : fal_pkg::ST_OK;
		end else begin
			status_c = range_c ? fal_pkg::ST_RANGE : fal_pkg::ST_OK;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			fal_pkg::S_IDLE: begin
				if (req_valid) begin
					if (req.req_type == fal_pkg::REQ_REMOVE && !range_c) begin
						state_d = fal_pkg::S_SHIFT;
					end else begin
						state_d = fal_pkg::S_RESP;
					end
				end
			end
			fal_pkg::S_SHIFT: begin
				if (!issue_c) begin
					state_d = fal_pkg::S_RESP;
				end
			end
			fal_pkg::S_RESP: begin
				if (out_free) begin
					state_d = fal_pkg::S_IDLE;
				end
			end
			default: state_d = fal_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ram      = '0;
		busy     = (state_q != fal_pkg::S_IDLE);
		res_load = 1'b0;
		res.read_value  = is_read_q ? rdata : '0;
		res.list_length = fal_pkg::len_t'(count_q);
		res.status      = status_q;
		case (state_q)
			fal_pkg::S_IDLE: begin
				if (req_valid) begin
					case (req.req_type)
						fal_pkg::REQ_APPEND: begin
							ram.we    = !full_c;
							ram.waddr = count_q[fal_pkg::ADDR_W-1:0];
							ram.wdata = req.value;
						end
						fal_pkg::REQ_READ: begin
							ram.re    = !range_c;
							ram.raddr = idx_c[fal_pkg::ADDR_W-1:0];
						end
						fal_pkg::REQ_WRITE: begin
							ram.we    = !range_c;
							ram.waddr = idx_c[fal_pkg::ADDR_W-1:0];
							ram.wdata = req.value;
						end
						default: ;
					endcase
				end
			end
			fal_pkg::S_SHIFT: begin
				ram.re    = issue_c;
				ram.raddr = rptr_q[fal_pkg::ADDR_W-1:0];
				ram.we    = pend_s1;
				ram.waddr = waddr_s1;
				ram.wdata = rdata;
			end
			fal_pkg::S_RESP: begin
				res_load = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fal_pkg::S_IDLE;
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == fal_pkg::S_SHIFT) && issue_c;
			if (accept_c && req.req_type == fal_pkg::REQ_APPEND && !full_c) begin
				count_q <= count_q + 1'b1;
			end else if (state_q == fal_pkg::S_SHIFT && !issue_c) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			status_q  <= status_c;
			is_read_q <= (req.req_type == fal_pkg::REQ_READ) && !range_c;
			rptr_q    <= fal_pkg::cnt_t'(idx_c + 1'b1);
		end else if (state_q == fal_pkg::S_SHIFT) begin
			waddr_s1 <= fal_pkg::addr_t'(rptr_q - 1'b1);
			if (issue_c) begin
				rptr_q <= rptr_q + 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= fal_pkg::cnt_t'(fal_pkg::CAPACITY))
		else $error("list length beyond capacity");

	a_no_pending_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fal_pkg::S_IDLE |-> !pend_s1)
		else $error("shift write pending while idle");

	a_remove_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fal_pkg::S_SHIFT && !issue_c |=> count_q == $past(count_q) - 1'b1)
		else $error("remove did not shorten the list by one");

	a_load_in_resp: assert property (@(posedge clk) disable iff (!arst_n)
		res_load |-> state_q == fal_pkg::S_RESP)
		else $error("result loaded outside the response state");

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking bench for the fixed-capacity list
//
// A clocked driver offers request items from a queue that the stimulus
// block fills, and predicts each result from its own copy of the list
// when the request is accepted. A clocked monitor compares every accepted
// result with the oldest prediction. The run goes through directed
// requests, a fill to capacity, and random phases with and without idling,
// including a long hold-off on the result side.
// ============================================================================
module tb;

	import fal_pkg::*;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;

	typedef enum {
		PH_DIRECT,
		PH_FREE,
		PH_SEND_IDLE,
		PH_RECV_STALL,
		PH_BOTH,
		PH_PRESSURE
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	phase_t phase = PH_DIRECT;
	req_t pending_q[$];
	rsp_t want_q[$];
	int errors = 0;
	int cycles = 0;
	int plan_count = 0;

	logic signed [DATA_W-1:0] list_words [CAPACITY];
	int list_count = 0;

	bit hold_used = 1'b0;
	int hold_left = 0;
	bit drv_busy;
	rsp_t got;
	rsp_t want;

	fixed_array_list u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int send_idle_pct(phase_t p);
		case (p)
			PH_SEND_IDLE: return 85;
			PH_BOTH:      return 30;
			default:      return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(phase_t p);
		case (p)
			PH_RECV_STALL: return 85;
			PH_BOTH:       return 30;
			default:       return 0;
		endcase
	endfunction

	function automatic rsp_t list_apply(req_t r);
		rsp_t o;
		int i;
		o.read_value = '0;
		o.status = ST_OK;
		if (r.req_type == REQ_APPEND) begin
			if (list_count >= CAPACITY) begin
				o.status = ST_FULL;
			end else begin
				list_words[list_count] = r.value;
				list_count++;
			end
		end else if (int'(r.index) >= list_count) begin
			o.status = ST_RANGE;
		end else begin
			case (r.req_type)
				REQ_READ: begin
					o.read_value = list_words[r.index];
				end
				REQ_WRITE: begin
					list_words[r.index] = r.value;
				end
				default: begin
					for (i = int'(r.index); i + 1 < list_count; i++)
						list_words[i] = list_words[i + 1];
					list_count--;
				end
			endcase
		end
		o.list_length = len_t'(list_count);
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			drv_busy = req_valid;
			if (req_valid && !req_stall) begin
				want_q.push_back(list_apply(req));
				drv_busy = 1'b0;
			end
			if (!drv_busy) begin
				if (pending_q.size() > 0 && $urandom_range(99) >= send_idle_pct(phase)) begin
					req <= pending_q.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (phase == PH_PRESSURE && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= ($urandom_range(99) < recv_stall_pct(phase));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			got = rsp;
			if (want_q.size() == 0) begin
				$error("result with nothing expected: read_value %0d list_length %0d status %0d",
					got.read_value, got.list_length, got.status);
				errors++;
			end else begin
				want = want_q.pop_front();
				if (got.read_value !== want.read_value) begin
					$error("read_value expected %0d actual %0d", want.read_value, got.read_value);
					errors++;
				end
				if (got.list_length !== want.list_length) begin
					$error("list_length expected %0d actual %0d",
						want.list_length, got.list_length);
					errors++;
				end
				if (got.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb NOT OK");
			$finish;
		end
	end

	task automatic queue_item(req_type_t t, int idx, logic [DATA_W-1:0] v);
		req_t r;
		r.req_type = t;
		r.index = idx[IDX_W-1:0];
		r.value = v;
		pending_q.push_back(r);
		if (t == REQ_APPEND) begin
			if (plan_count < CAPACITY)
				plan_count++;
		end else if (t == REQ_REMOVE && int'(r.index) < plan_count) begin
			plan_count--;
		end
	endtask

	function automatic logic [DATA_W-1:0] random_word();
		case ($urandom_range(15))
			0:       return 32'h7FFF_FFFF;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int random_target();
		case ($urandom_range(3))
			0:       return $urandom_range(4);
			1:       return CAPACITY;
			2:       return $urandom_range(CAPACITY);
			default: return $urandom_range(CAPACITY, CAPACITY - 3);
		endcase
	endfunction

	task automatic queue_random(int n);
		int k;
		int pick;
		int idx;
		int target;
		bit grow;
		req_type_t t;
		target = random_target();
		for (k = 0; k < n; k++) begin
			if ($urandom_range(31) == 0)
				target = random_target();
			if (plan_count == target)
				grow = 1'($urandom_range(1));
			else
				grow = (plan_count < target);
			idx = (plan_count > 0) ? $urandom_range(plan_count - 1) : 0;
			pick = $urandom_range(99);
			if (pick < 50)
				t = grow ? REQ_APPEND : REQ_REMOVE;
			else if (pick < 60)
				t = grow ? REQ_REMOVE : REQ_APPEND;
			else if (pick < 78)
				t = REQ_READ;
			else if (pick < 92)
				t = REQ_WRITE;
			else begin
				t = req_type_t'($urandom_range(3));
				idx = $urandom_range(127);
			end
			queue_item(t, idx, random_word());
		end
	endtask

	task automatic drain();
		while (pending_q.size() != 0 || req_valid)
			@(negedge clk);
		while (want_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		phase = PH_DIRECT;
		queue_item(REQ_READ, 0, 32'h0);
		queue_item(REQ_REMOVE, 0, 32'h0);
		queue_item(REQ_WRITE, 127, 32'hFFFF_FFFF);
		queue_item(REQ_APPEND, 0, 32'h7FFF_FFFF);
		queue_item(REQ_APPEND, 127, 32'h8000_0000);
		queue_item(REQ_APPEND, 0, 32'h0000_0000);
		queue_item(REQ_APPEND, 0, 32'hFFFF_FFFF);
		queue_item(REQ_READ, 0, 32'h0);
		queue_item(REQ_READ, 3, 32'hFFFF_FFFF);
		queue_item(REQ_READ, 4, 32'h0);
		queue_item(REQ_READ, 127, 32'h0);
		queue_item(REQ_WRITE, 2, 32'h8000_0000);
		queue_item(REQ_READ, 2, 32'h0);
		queue_item(REQ_REMOVE, 0, 32'h0);
		queue_item(REQ_READ, 0, 32'h0);
		queue_item(REQ_READ, 2, 32'h0);
		queue_item(REQ_REMOVE, 2, 32'h0);
		queue_item(REQ_APPEND, 0, 32'h5555_5555);
		queue_item(REQ_WRITE, 3, 32'h1234_5678);
		queue_item(REQ_REMOVE, 1, 32'h0);
		queue_item(REQ_REMOVE, 0, 32'h0);
		queue_item(REQ_REMOVE, 0, 32'h0);
		queue_item(REQ_REMOVE, 0, 32'h0);
		queue_item(REQ_APPEND, 0, 32'h2AAA_AAAA);
		drain();

		while (plan_count < CAPACITY)
			queue_item(REQ_APPEND, 0, random_word());
		queue_item(REQ_APPEND, 0, random_word());
		queue_item(REQ_APPEND, 0, random_word());
		queue_item(REQ_READ, 127, 32'h0);
		queue_item(REQ_WRITE, 127, random_word());
		queue_item(REQ_REMOVE, 0, 32'h0);
		queue_item(REQ_READ, 127, 32'h0);
		queue_item(REQ_READ, 126, 32'h0);
		drain();

		phase = PH_FREE;
		queue_random(160);
		drain();
		phase = PH_SEND_IDLE;
		queue_random(120);
		drain();
		phase = PH_RECV_STALL;
		queue_random(120);
		drain();
		phase = PH_BOTH;
		queue_random(160);
		drain();
		phase = PH_PRESSURE;
		queue_random(80);
		drain();

		repeat (CAPACITY + 8) @(negedge clk);
		if (errors == 0 && want_q.size() == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

endmodule
